// File: hw/rtl/isb_pkg.sv
// shared types and constants for the interval subtract block
package isb_pkg;

  localparam int ADDR_W           = 64;
  localparam int TAG_W            = 8;
  localparam int MODE_W           = 2;
  localparam int MAX_BLOCKERS_DEF = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_FINISH
  } state_t;

  // control into the scan accumulator
  typedef struct packed {
    logic              clear;
    logic              valid;
    logic [ADDR_W-1:0] cursor;
  } scan_ctl_t;

  // summary of one pass over the table
  typedef struct packed {
    logic              any;
    logic              cov;
    logic [ADDR_W-1:0] max_end;
    logic              min_v;
    logic [ADDR_W-1:0] min_start;
  } scan_stat_t;

endpackage

// File: hw/rtl/isb_ram.sv
// generic single write port ram with registered read
module isb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/isb_scan.sv
// accumulates coverage and next blocker start over one pass of the table
module isb_scan import isb_pkg::*; (
  input  logic              clk,
  input  scan_ctl_t         ctl,
  input  logic [ADDR_W-1:0] qs,
  input  logic [ADDR_W-1:0] qe,
  input  logic [ADDR_W-1:0] bs,
  input  logic [ADDR_W-1:0] be,
  output scan_stat_t        stat
);

  logic ovl;
  logic covers;
  logic ahead;

  // entry overlaps the query, then its relation to the cursor
  assign ovl    = (bs < be) && (qs < be) && (bs < qe);
  assign covers = ovl && (bs <= ctl.cursor) && (be > ctl.cursor);
  assign ahead  = ovl && (bs > ctl.cursor);

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      stat.any   <= 1'b0;
      stat.cov   <= 1'b0;
      stat.min_v <= 1'b0;
    end else if (ctl.valid) begin
      if (ovl) begin
        stat.any <= 1'b1;
      end
      if (covers) begin
        stat.cov <= 1'b1;
        if (!stat.cov || be > stat.max_end) begin
          stat.max_end <= be;
        end
      end
      if (ahead) begin
        stat.min_v <= 1'b1;
        if (!stat.min_v || bs < stat.min_start) begin
          stat.min_start <= bs;
        end
      end
    end
  end

endmodule

// File: hw/rtl/interval_subtract_blockers.sv
// top level: blocker table, query sequencer and result register
//
// Usage: an item (mode, span_start, span_end, range_tag) is taken when
// start is high and busy is low. Clear, add and unknown-mode items give one
// acknowledge result in the next cycle and leave busy low, so another item
// may follow at once. An add to a full table is acknowledged with rejected.
// A query sets busy and runs passes over the blocker table, which sits in a
// ram with registered read. Each pass reads every stored entry, one a cycle,
// and either jumps the cursor past the blockers covering it or finds the
// next piece, ending at the nearest blocker start ahead of it or at the span
// end. A query runs P + 1 passes, P being at most the number of pieces plus
// covered stretches. Results come out as one-cycle strobes on result_strobe,
// in ascending address order, the final one with last_piece; a piece found
// in a pass is kept in a pending register until the next decision or the
// finish state and is then registered onto the outputs. The receiver cannot
// stall; no result is held. Reset empties the table and returns to idle; the
// table contents themselves are not cleared.
module interval_subtract_blockers import isb_pkg::*; #(
  parameter int MAX_BLOCKERS = MAX_BLOCKERS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [MODE_W-1:0] mode,
  input  logic [ADDR_W-1:0] span_start,
  input  logic [ADDR_W-1:0] span_end,
  input  logic [TAG_W-1:0]  range_tag,
  output logic              result_strobe,
  output logic [ADDR_W-1:0] piece_start,
  output logic [ADDR_W-1:0] piece_end,
  output logic [TAG_W-1:0]  piece_tag,
  output logic              no_piece,
  output logic              rejected,
  output logic              last_piece
);

  localparam int CW = $clog2(MAX_BLOCKERS + 1);
  localparam int AW = (MAX_BLOCKERS > 1) ? $clog2(MAX_BLOCKERS) : 1;
  localparam logic [CW-1:0] FULL = CW'(MAX_BLOCKERS);

  state_t state, state_next;

  logic [CW-1:0]     count;
  logic [CW-1:0]     rd_idx;
  logic              rd_v;
  logic              first;
  logic [ADDR_W-1:0] qs, qe, cursor;
  logic [TAG_W-1:0]  tag;
  logic              pend_v;
  logic [ADDR_W-1:0] pend_s, pend_e;

  logic                  ram_we;
  logic [2*ADDR_W-1:0]   ram_rdata;
  scan_ctl_t             sctl;
  scan_stat_t            sstat;

  // next-state and decision signals
  logic              accept;
  logic              emit;
  logic [ADDR_W-1:0] e_s, e_e;
  logic [TAG_W-1:0]  e_tag;
  logic              e_none, e_rej, e_last;
  logic              rescan;
  logic              new_pend;
  logic [ADDR_W-1:0] pe;
  logic [ADDR_W-1:0] cursor_next;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);
  assign ram_we = accept && (mode_t'(mode) == MODE_ADD) && (count < FULL);

  // blocker table, start in the upper half and end in the lower
  isb_ram #(.WIDTH(2*ADDR_W), .DEPTH(MAX_BLOCKERS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata ({span_start, span_end}),
    .raddr (rd_idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  isb_scan u_scan (
    .clk  (clk),
    .ctl  (sctl),
    .qs   (qs),
    .qe   (qe),
    .bs   (ram_rdata[2*ADDR_W-1:ADDR_W]),
    .be   (ram_rdata[ADDR_W-1:0]),
    .stat (sstat)
  );

  // end of the piece found in this pass
  assign pe = (sstat.min_v && sstat.min_start < qe) ? sstat.min_start : qe;

  // sequencer
  always_comb begin
    state_next  = state;
    emit        = 1'b0;
    e_s         = '0;
    e_e         = '0;
    e_tag       = '0;
    e_none      = 1'b1;
    e_rej       = 1'b0;
    e_last      = 1'b1;
    rescan      = 1'b0;
    new_pend    = 1'b0;
    cursor_next = cursor;
    sctl.clear  = 1'b0;
    sctl.valid  = rd_v;
    sctl.cursor = cursor;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (mode_t'(mode) == MODE_QUERY) begin
            state_next  = ST_SCAN;
            sctl.clear  = 1'b1;
            cursor_next = span_start;
          end else begin
            emit  = 1'b1;
            e_rej = (mode_t'(mode) == MODE_ADD) && (count >= FULL);
          end
        end
      end
      ST_SCAN: begin
        if (rd_idx == count && !rd_v) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (first && !sstat.any) begin
          emit       = 1'b1;
          e_s        = qs;
          e_e        = qe;
          e_tag      = tag;
          e_none     = 1'b0;
          state_next = ST_IDLE;
        end else if (qs >= qe) begin
          emit       = 1'b1;
          e_tag      = tag;
          state_next = ST_IDLE;
        end else if (sstat.cov) begin
          cursor_next = sstat.max_end;
          if (sstat.max_end >= qe) begin
            state_next = ST_FINISH;
          end else begin
            rescan = 1'b1;
          end
        end else begin
          new_pend    = 1'b1;
          cursor_next = pe;
          if (pend_v) begin
            emit   = 1'b1;
            e_s    = pend_s;
            e_e    = pend_e;
            e_tag  = tag;
            e_none = 1'b0;
            e_last = 1'b0;
          end
          if (pe >= qe) begin
            state_next = ST_FINISH;
          end else begin
            rescan = 1'b1;
          end
        end
        if (rescan) begin
          state_next = ST_SCAN;
          sctl.clear = 1'b1;
        end
      end
      ST_FINISH: begin
        emit       = 1'b1;
        e_tag      = tag;
        state_next = ST_IDLE;
        if (pend_v) begin
          e_s    = pend_s;
          e_e    = pend_e;
          e_none = 1'b0;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      rd_idx        <= '0;
      rd_v          <= 1'b0;
      first         <= 1'b0;
      pend_v        <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      result_strobe <= emit;
      if (accept && mode_t'(mode) == MODE_CLEAR) begin
        count <= '0;
      end else if (ram_we) begin
        count <= count + 1'b1;
      end
      if (sctl.clear) begin
        rd_idx <= '0;
        rd_v   <= 1'b0;
      end else if (state == ST_SCAN) begin
        rd_v <= (rd_idx < count);
        if (rd_idx < count) begin
          rd_idx <= rd_idx + 1'b1;
        end
      end
      if (state == ST_IDLE) begin
        first  <= 1'b1;
        pend_v <= 1'b0;
      end else if (state == ST_DECIDE) begin
        first <= 1'b0;
        if (new_pend) begin
          pend_v <= 1'b1;
        end
      end
    end
  end

  // query and result payload
  always_ff @(posedge clk) begin
    cursor <= cursor_next;
    if (accept) begin
      qs  <= span_start;
      qe  <= span_end;
      tag <= range_tag;
    end
    if (new_pend) begin
      pend_s <= cursor;
      pend_e <= pe;
    end
    if (emit) begin
      piece_start <= e_s;
      piece_end   <= e_e;
      piece_tag   <= e_tag;
      no_piece    <= e_none;
      rejected    <= e_rej;
      last_piece  <= e_last;
    end
  end

endmodule

// File: hw/rtl/isb_checker.sv
// port-level checks for the interval subtract block, bound to the top level
module isb_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic result_strobe,
  input logic no_piece,
  input logic rejected,
  input logic last_piece
);

  // a rejected add is a bare acknowledge
  a_rej_ack: assert property (@(posedge clk) disable iff (rst)
    result_strobe && rejected |-> no_piece && last_piece)
    else $error("rejected result is not a final acknowledge");

  // an empty result always ends its transaction
  a_none_last: assert property (@(posedge clk) disable iff (rst)
    result_strobe && no_piece |-> last_piece)
    else $error("result without piece is not last");

  // more pieces pending keeps the block busy
  a_more_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !last_piece |-> busy)
    else $error("idle while a query has pieces left");

  // every accepted transaction answers or goes busy next cycle
  a_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || result_strobe)
    else $error("accepted transaction gave no response");

endmodule

bind interval_subtract_blockers isb_checker u_isb_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .result_strobe (result_strobe),
  .no_piece      (no_piece),
  .rejected      (rejected),
  .last_piece    (last_piece)
);
